// ===== rtl/chs_pkg.sv =====
// Shared types and constants for the chained hash set.
`timescale 1ns / 1ps

package chs_pkg;

    // Field widths of the stream words.
    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int M_DATA_W = 8;

    // Default geometry of the table.
    localparam int DEF_BUCKETS    = 11;
    localparam int DEF_POOL_NODES = 64;

    // The remainder unit splits the key into digits of this many bits.
    localparam int HASH_DIGIT = 4;
    localparam int HASH_STEPS = KEY_W / HASH_DIGIT;

    // Command codes carried in s_tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2
    } cmd_t;

    // Result codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_LOOK,
        S_WALK,
        S_UNLINK,
        S_FREE,
        S_RESULT
    } state_t;

    // Finished result handed to the output register.
    typedef struct packed {
        logic    valid;
        status_t status;
    } res_t;

endpackage

// ===== rtl/chs_hash.sv =====
// Non-negative remainder of a signed key by the bucket count, in three pipelined steps.
`timescale 1ns / 1ps

module chs_hash #(
    parameter int BUCKETS = chs_pkg::DEF_BUCKETS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [chs_pkg::KEY_W-1:0]   key,
    output logic                        done,
    output logic [$clog2(BUCKETS)-1:0]  bucket
);
    import chs_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int QW = HASH_DIGIT + $clog2(HASH_STEPS);
    localparam int SW = BW + QW;
    localparam int SH = SW + BW;
    localparam logic [BW:0]   B_L     = (BW+1)'(BUCKETS);
    localparam logic [SW-1:0] B_S     = SW'(BUCKETS);
    localparam logic [63:0]   RECIP64 = ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [SH-1:0] RECIP   = SH'(RECIP64);
    localparam logic [63:0]   WRAP64  = (64'd1 << KEY_W) % BUCKETS;
    localparam logic [BW-1:0] WRAP    = BW'(WRAP64);
    localparam logic [BW:0]   ADD_L   = B_L - {1'b0, WRAP};

    logic [SW-1:0]     part [HASH_STEPS];
    logic [SW-1:0]     sum_next;
    logic [SW+SH-1:0]  prod;
    logic [QW-1:0]     quot_next;
    logic [SW-1:0]     rem_full;
    logic [BW-1:0]     rem_next;
    logic              sum_vld_reg;
    logic              quot_vld_reg;
    logic              done_reg;
    logic [SW-1:0]     sum_reg;
    logic [QW-1:0]     quot_reg;
    logic [BW-1:0]     rem_reg;
    logic              neg_reg;
    logic [BW:0]       fix_sum;

    // Each key digit times its place weight, which is the digit base power mod BUCKETS.
    for (genvar g = 0; g < HASH_STEPS; g++) begin : g_fold
        localparam logic [BW-1:0] WEIGHT = BW'((64'd1 << (HASH_DIGIT * g)) % BUCKETS);
        assign part[g] = SW'(key[HASH_DIGIT*g +: HASH_DIGIT]) * SW'(WEIGHT);
    end

    // The weighted digit sum keeps the remainder of the unsigned key and stays small.
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < HASH_STEPS; i++) begin
            sum_next = sum_next + part[i];
        end
    end

    // The quotient of the small sum comes exactly from a scaled reciprocal.
    assign prod      = (SW+SH)'(sum_reg) * (SW+SH)'(RECIP);
    assign quot_next = prod[SH +: QW];
    assign rem_full  = sum_reg - SW'(quot_reg) * B_S;
    assign rem_next  = rem_full[BW-1:0];

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg  <= 1'b0;
            quot_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            sum_vld_reg  <= start;
            quot_vld_reg <= sum_vld_reg;
            done_reg     <= quot_vld_reg;
        end
    end

    // Digit sum, quotient and remainder registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            sum_reg <= sum_next;
            neg_reg <= key[KEY_W-1];
        end
        if (sum_vld_reg) begin
            quot_reg <= quot_next;
        end
        if (quot_vld_reg) begin
            rem_reg <= rem_next;
        end
    end

    // A negative key reads as the unsigned word less 2^32, so take 2^32 mod BUCKETS back out.
    assign fix_sum = ({1'b0, rem_reg} >= {1'b0, WRAP}) ? ({1'b0, rem_reg} - {1'b0, WRAP})
                                                       : ({1'b0, rem_reg} + ADD_L);
    assign bucket  = neg_reg ? fix_sum[BW-1:0] : rem_reg;
    assign done    = done_reg;

    // The sequencer never restarts a division that is still running.
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !sum_vld_reg && !quot_vld_reg && !done_reg)
        else $error("hash restarted while busy");

    // The bucket index stays inside the table.
    a_bucket_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> {1'b0, bucket} < B_L)
        else $error("bucket index out of range");

    // The done flag is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("hash done held for more than one cycle");

endmodule

// ===== rtl/chs_engine.sv =====
// Sequencer, bucket head memory and node memory of the chained hash set.
`timescale 1ns / 1ps

module chs_engine #(
    parameter int BUCKETS    = chs_pkg::DEF_BUCKETS,
    parameter int POOL_NODES = chs_pkg::DEF_POOL_NODES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [chs_pkg::CMD_W-1:0]   in_cmd,
    input  logic [chs_pkg::KEY_W-1:0]   in_key,
    output chs_pkg::res_t               res,
    input  logic                        res_ready
);
    import chs_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int IW = $clog2(POOL_NODES + 1);
    localparam int NW = $clog2(POOL_NODES);
    localparam int EW = KEY_W + IW;
    localparam logic [IW-1:0] NIL       = IW'(POOL_NODES);
    localparam logic [IW-1:0] STEP_LAST = IW'(POOL_NODES - 1);
    localparam logic [BW-1:0] CLR_LAST  = BW'(BUCKETS - 1);

    // Memories: chain heads per bucket, and key plus link per node.
    logic [IW-1:0] head_mem [BUCKETS];
    logic [EW-1:0] node_mem [POOL_NODES];

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [BW-1:0]     bucket_reg, bucket_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     prev_reg, prev_next;
    logic [KEY_W-1:0]  prev_key_reg, prev_key_next;
    logic [IW-1:0]     free_head_reg, free_head_next;
    logic [IW-1:0]     fresh_reg, fresh_next;
    logic [IW-1:0]     steps_reg, steps_next;
    logic [BW-1:0]     clr_reg, clr_next;
    status_t           status_reg, status_next;

    logic [IW-1:0]     head_q_reg;
    logic [EW-1:0]     node_q_reg;

    logic              head_re, head_we;
    logic [BW-1:0]     head_raddr, head_waddr;
    logic [IW-1:0]     head_wdata;
    logic              node_re, node_we;
    logic [IW-1:0]     node_raddr, node_waddr;
    logic [EW-1:0]     node_wdata;

    logic              hash_start, hash_done;
    logic [BW-1:0]     hash_bucket;

    logic [KEY_W-1:0]  q_key;
    logic [IW-1:0]     q_link;
    logic              key_hit;
    logic              have_free, have_fresh;
    logic [IW-1:0]     alloc_node;
    logic              is_add;

    function automatic logic [IW-1:0] clip_link(input logic [IW-1:0] l);
        return (l < NIL) ? l : NIL;
    endfunction

    chs_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (in_key),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    // Head memory: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re) begin
            head_q_reg <= head_mem[head_raddr];
        end
    end

    // Node memory: the read word holds until the next read.
    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr[NW-1:0]] <= node_wdata;
        end
        if (node_re) begin
            node_q_reg <= node_mem[node_raddr[NW-1:0]];
        end
    end

    // Decode of the node word and allocation choice.
    assign q_key      = node_q_reg[EW-1:IW];
    assign q_link     = clip_link(node_q_reg[IW-1:0]);
    assign key_hit    = (q_key == key_reg);
    assign have_free  = (free_head_reg != NIL);
    assign have_fresh = (fresh_reg != NIL);
    assign alloc_node = have_free ? free_head_reg : fresh_reg;
    assign is_add     = (cmd_reg == CMD_ADD);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    if (in_cmd == CMD_ADD || in_cmd == CMD_REMOVE || in_cmd == CMD_FIND) begin
                        state_next = S_HASH;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                if (is_add || head_q_reg == NIL) begin
                    state_next = S_RESULT;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (key_hit) begin
                    state_next = (cmd_reg == CMD_REMOVE) ? S_UNLINK : S_RESULT;
                end else if (q_link == NIL || steps_reg == STEP_LAST) begin
                    state_next = S_RESULT;
                end
            end
            S_UNLINK: state_next = S_FREE;
            S_FREE:   state_next = S_RESULT;
            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Memory ports, hash start and handshakes.
    always_comb begin
        in_ready   = 1'b0;
        hash_start = 1'b0;
        head_re    = 1'b0;
        head_raddr = hash_bucket;
        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = alloc_node;
        node_re    = 1'b0;
        node_raddr = free_head_reg;
        node_we    = 1'b0;
        node_waddr = alloc_node;
        node_wdata = {key_reg, head_q_reg};
        res.valid  = 1'b0;
        res.status = status_reg;
        unique case (state_reg)
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = NIL;
            end
            S_IDLE: begin
                in_ready   = 1'b1;
                hash_start = in_valid &&
                    (in_cmd == CMD_ADD || in_cmd == CMD_REMOVE || in_cmd == CMD_FIND);
            end
            S_HASH: begin
                // Fetch the chain head and the link of the first free node together.
                head_re = hash_done;
                node_re = hash_done && have_free;
            end
            S_LOOK: begin
                if (is_add) begin
                    if (have_free || have_fresh) begin
                        node_we = 1'b1;
                        head_we = 1'b1;
                    end
                end else if (head_q_reg != NIL) begin
                    node_re    = 1'b1;
                    node_raddr = head_q_reg;
                end
            end
            S_WALK: begin
                if (!key_hit && q_link != NIL && steps_reg != STEP_LAST) begin
                    node_re    = 1'b1;
                    node_raddr = q_link;
                end
            end
            S_UNLINK: begin
                // Bypass the matched node from its predecessor or from the head.
                if (prev_reg == NIL) begin
                    head_we    = 1'b1;
                    head_wdata = q_link;
                end else begin
                    node_we    = 1'b1;
                    node_waddr = prev_reg;
                    node_wdata = {prev_key_reg, q_link};
                end
            end
            S_FREE: begin
                node_we    = 1'b1;
                node_waddr = cur_reg;
                node_wdata = {key_reg, free_head_reg};
            end
            S_RESULT: begin
                res.valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Datapath register updates.
    always_comb begin
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        bucket_next    = bucket_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_key_next  = prev_key_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        steps_next     = steps_reg;
        clr_next       = clr_reg;
        status_next    = status_reg;
        unique case (state_reg)
            S_CLEAR: clr_next = clr_reg + 1'b1;
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next    = in_cmd;
                    key_next    = in_key;
                    status_next = ST_ABSENT;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    bucket_next = hash_bucket;
                end
            end
            S_LOOK: begin
                if (is_add) begin
                    if (have_free) begin
                        free_head_next = q_link;
                        status_next    = ST_OK;
                    end else if (have_fresh) begin
                        fresh_next  = fresh_reg + 1'b1;
                        status_next = ST_OK;
                    end else begin
                        status_next = ST_FULL;
                    end
                end else begin
                    cur_next    = head_q_reg;
                    prev_next   = NIL;
                    steps_next  = '0;
                    status_next = ST_ABSENT;
                end
            end
            S_WALK: begin
                if (key_hit) begin
                    status_next = ST_OK;
                end else begin
                    prev_next     = cur_reg;
                    prev_key_next = q_key;
                    cur_next      = q_link;
                    steps_next    = steps_reg + 1'b1;
                end
            end
            S_FREE: free_head_next = cur_reg;
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= NIL;
            fresh_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        bucket_reg   <= bucket_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_key_reg <= prev_key_next;
        steps_reg    <= steps_next;
        status_reg   <= status_next;
    end

    // The never-used counter cannot pass the pool size.
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= NIL)
        else $error("fresh node count past pool size");

    // Memory reads never coincide with a write to the same node.
    a_node_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        (node_we && node_re) |-> node_waddr != node_raddr)
        else $error("node read and write collide");

    // A node handed to the free list is the one whose key just matched.
    a_free_match: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FREE |-> $past(state_reg, 2) == S_WALK && q_key == key_reg)
        else $error("freed node does not hold the key");

    // A finished result holds until it is taken.
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res_ready) |=> res.valid && $stable(res.status))
        else $error("result dropped before hand-off");

endmodule

// ===== rtl/chained_hash_set.sv =====
// Top level of the chained hash set: stream ports, output register and the engine.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  s_tuser = command, s_tdata = value
//  m_       out        m_tvalid/m_tready  m_tdata = status
//
// One word at a time. An add goes through S_HASH and then S_LOOK, which writes the node
// and chain head, to S_RESULT and the output register; find and remove walk the chain in
// S_WALK, and a remove that hits adds S_UNLINK and S_FREE for the unlink and free writes.
// The bucket comes from a three-stage remainder unit: a weighted digit sum, a reciprocal
// multiply, a subtract. The chain walk reads one node per cycle from the single read port
// of the node memory. After reset a clearing pass nulls every chain head; s_tready stays
// low meanwhile. A new word is taken while the previous status waits on m_tready.
`timescale 1ns / 1ps

module chained_hash_set #(
    parameter int BUCKETS    = chs_pkg::DEF_BUCKETS,
    parameter int POOL_NODES = chs_pkg::DEF_POOL_NODES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [chs_pkg::KEY_W-1:0]     s_tdata,   // [31:0] value
    input  logic [chs_pkg::CMD_W-1:0]     s_tuser,   // [1:0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [chs_pkg::M_DATA_W-1:0]  m_tdata    // [1:0] status, [7:2] zero
);
    import chs_pkg::*;

    res_t     res;
    logic     res_ready;
    logic     m_tvalid_reg;
    status_t  m_status_reg;

    chs_engine #(
        .BUCKETS    (BUCKETS),
        .POOL_NODES (POOL_NODES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_key    (s_tdata),
        .res       (res),
        .res_ready (res_ready)
    );

    // Output register takes a result when empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && res_ready) begin
            m_status_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_DATA_W - STATUS_W)'(0), m_status_reg};

endmodule
